// ===== hdl/min_length_window_sum_at_least_top_macros.svh =====
// Assertion macros for the min_length_window_sum_at_least checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef MIN_LENGTH_WINDOW_SUM_AT_LEAST_TOP_MACROS_SVH
`define MIN_LENGTH_WINDOW_SUM_AT_LEAST_TOP_MACROS_SVH

// Same-cycle implication.
`define MLWSUM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlwsum assertion failed");

// Next-cycle implication.
`define MLWSUM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlwsum assertion failed");

`endif

// ===== hdl/mlwsum_pkg.sv =====
// Shared constants, types and helpers for the shortest-window-sum block.
// No dependencies; used by every other file of the block but the macros header.
package mlwsum_pkg;

	localparam int WINDOW_DEPTH = 1024;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int PSUM_W       = PTR_W + 1;
	localparam int SAMPLE_W     = 16;
	localparam int TARGET_W     = 32;
	localparam int SUM_W        = 33;
	localparam int LEN_W        = 11;
	localparam int LEN_MAX      = 2047;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                is_last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FULL,
		ST_CHECK,
		ST_POP,
		ST_EMIT
	} state_t;

	// Clamp a window length to the result field.
	function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] n);
		return (32'(n) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(n);
	endfunction

endpackage

// ===== hdl/min_length_window_sum_at_least_top.sv =====
// Top level of the shortest-window-sum block: front queue plus back engine.
// Depends on mlwsum_pkg, mlwsum_front and mlwsum_back.
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------
//  input   | in_valid / in_stall              | sample_value, is_last
//  output  | out_valid / out_stall            | min_length, overflowed
//  config  | cfg_wr_en / cfg_wr_data          | target_sum (32 bit)
//
// Steps: an item is pushed into the store (a full store instead replaces its
// oldest sample), then compared; each sample dropped from the front (registered
// store read, subtract) is compared again, and the last item loads the result.
// Reset: arst_n clears the queue, window state and result valid; target_sum
// returns to 1. The window store itself is not cleared.
// Stalls: a 4-entry queue absorbs input while the back end iterates; a held
// result only blocks the back end when the next result is ready to load.
module min_length_window_sum_at_least_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample_value,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] min_length,
	output logic        overflowed
);

	// hand-off between queue and engine
	logic              q_valid;
	logic              q_pop;
	mlwsum_pkg::item_t q_item;

	// front: takes every input transfer while the queue has room
	mlwsum_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.is_last      (is_last),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	// back: window store, removal loop, result register
	mlwsum_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.min_length  (min_length),
		.overflowed  (overflowed)
	);

endmodule

// ===== hdl/mlwsum_front.sv =====
// Front end: accepts input transfers into a short item queue.
// Depends on mlwsum_pkg.
module mlwsum_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        sample_value,
	input  logic               is_last,
	output logic               q_valid,
	output mlwsum_pkg::item_t  q_item,
	input  logic               q_pop
);

	mlwsum_pkg::item_t                  q_mem_q [mlwsum_pkg::QUEUE_DEPTH];
	logic [mlwsum_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [mlwsum_pkg::QCNT_W-1:0]      count_q;
	logic                               push, pop;

	assign in_stall = (count_q == mlwsum_pkg::QCNT_W'(mlwsum_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	function automatic logic [mlwsum_pkg::QPTR_W-1:0] qinc(
		input logic [mlwsum_pkg::QPTR_W-1:0] p);
		return (p == mlwsum_pkg::QPTR_W'(mlwsum_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + mlwsum_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{sample: sample_value, is_last: is_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= qinc(wr_ptr_q);
			if (pop)  rd_ptr_q <= qinc(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + mlwsum_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - mlwsum_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/mlwsum_back.sv =====
// Back end: window store, running sum, front removal loop and result register.
// Depends on mlwsum_pkg; fed by mlwsum_front.
module mlwsum_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               q_valid,
	input  mlwsum_pkg::item_t  q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        min_length,
	output logic               overflowed
);

	localparam int PTR_W  = mlwsum_pkg::PTR_W;
	localparam int CNT_W  = mlwsum_pkg::CNT_W;
	localparam int PSUM_W = mlwsum_pkg::PSUM_W;
	localparam int SUM_W  = mlwsum_pkg::SUM_W;
	localparam int SMP_W  = mlwsum_pkg::SAMPLE_W;

	// window store, one write and one registered read per cycle
	logic [SMP_W-1:0] mem_q [mlwsum_pkg::WINDOW_DEPTH];
	logic [SMP_W-1:0] rd_data_q;
	logic             mem_we;
	logic [PTR_W-1:0] mem_waddr;
	logic [SMP_W-1:0] mem_wdata;

	mlwsum_pkg::state_t state_q, state_d;
	mlwsum_pkg::item_t  item_q, item_d;
	logic [31:0]        target_q;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [PTR_W-1:0]   front_q, front_d, front_inc, push_pos;
	logic [PSUM_W-1:0]  pos_raw;
	logic [CNT_W-1:0]   count_q, count_d, best_q, best_d;
	logic               ovf_q, ovf_d;
	logic               full, out_load;
	logic               out_valid_q, ovf_out_q;
	logic [10:0]        len_out_q;

	assign full      = (count_q == CNT_W'(mlwsum_pkg::WINDOW_DEPTH));
	assign front_inc = (front_q == PTR_W'(mlwsum_pkg::WINDOW_DEPTH - 1)) ?
		'0 : front_q + PTR_W'(1);
	assign pos_raw   = PSUM_W'(front_q) + PSUM_W'(count_q);
	assign push_pos  = (pos_raw >= PSUM_W'(mlwsum_pkg::WINDOW_DEPTH)) ?
		PTR_W'(pos_raw - PSUM_W'(mlwsum_pkg::WINDOW_DEPTH)) : PTR_W'(pos_raw);

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		rd_data_q <= mem_q[front_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mlwsum_pkg::ST_IDLE;
			target_q <= 32'd1;
			sum_q    <= '0;
			front_q  <= '0;
			count_q  <= '0;
			best_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) target_q <= cfg_wr_data;
			sum_q   <= sum_d;
			front_q <= front_d;
			count_q <= count_d;
			best_q  <= best_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		sum_d     = sum_q;
		front_d   = front_q;
		count_d   = count_q;
		best_d    = best_q;
		ovf_d     = ovf_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = push_pos;
		mem_wdata = q_item.sample;
		out_load  = 1'b0;
		case (state_q)
			mlwsum_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_item;
					if (full) begin
						// oldest entry is being read this cycle
						state_d = mlwsum_pkg::ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CNT_W'(1);
						sum_d   = sum_q + SUM_W'(q_item.sample);
						state_d = mlwsum_pkg::ST_CHECK;
					end
				end
			end
			mlwsum_pkg::ST_FULL: begin
				// drop oldest and reuse its slot for the new sample
				mem_we    = 1'b1;
				mem_waddr = front_q;
				mem_wdata = item_q.sample;
				sum_d     = sum_q - SUM_W'(rd_data_q) + SUM_W'(item_q.sample);
				front_d   = front_inc;
				state_d   = mlwsum_pkg::ST_CHECK;
			end
			mlwsum_pkg::ST_CHECK: begin
				if (count_q != '0 && sum_q >= SUM_W'(target_q)) begin
					if (best_q == '0 || count_q < best_q) best_d = count_q;
					state_d = mlwsum_pkg::ST_POP;
				end else begin
					if (full) ovf_d = 1'b1;
					state_d = item_q.is_last ? mlwsum_pkg::ST_EMIT : mlwsum_pkg::ST_IDLE;
				end
			end
			mlwsum_pkg::ST_POP: begin
				sum_d   = sum_q - SUM_W'(rd_data_q);
				front_d = front_inc;
				count_d = count_q - CNT_W'(1);
				state_d = mlwsum_pkg::ST_CHECK;
			end
			mlwsum_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					sum_d    = '0;
					front_d  = '0;
					count_d  = '0;
					best_d   = '0;
					ovf_d    = 1'b0;
					state_d  = mlwsum_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlwsum_pkg::ST_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			len_out_q <= mlwsum_pkg::sat_len(best_q);
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign min_length = len_out_q;
	assign overflowed = ovf_out_q;

endmodule

// ===== hdl/mlwsum_checker.sv =====
// Port-level checks for min_length_window_sum_at_least_top, bound to the top.
// Depends on mlwsum_pkg and min_length_window_sum_at_least_top_macros.svh.
`include "min_length_window_sum_at_least_top_macros.svh"

module mlwsum_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [31:0] cfg_wr_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] sample_value,
	input logic        is_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [10:0] min_length,
	input logic        overflowed
);

	// held result keeps its value
	`MLWSUM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(min_length) && $stable(overflowed))

	// a window never exceeds the store
	`MLWSUM_ASSERT_IMP(a_len_bound, out_valid, 32'(min_length) <= 32'(mlwsum_pkg::WINDOW_DEPTH))

	// queue only fills through an input transfer
	`MLWSUM_ASSERT_IMP(a_fill_cause, $rose(in_stall), $past(in_valid) && !$past(in_stall))

endmodule

bind min_length_window_sum_at_least_top mlwsum_checker u_mlwsum_checker (.*);
